// ===== hdl/vector_series_autocorrelation_defines.svh =====
// assertion macros for the autocorrelation block
`ifndef VECTOR_SERIES_AUTOCORRELATION_DEFINES_SVH
`define VECTOR_SERIES_AUTOCORRELATION_DEFINES_SVH

// same-cycle implication
`define VSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg
// shared constants and types of the vector series autocorrelation block
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int SERIES_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(SERIES_DEPTH);
    localparam int MAX_LAGS     = 64;
    localparam int LAGN_W       = $clog2(MAX_LAGS + 1);
    localparam int STEP_W       = 12;
    localparam int COMP_W       = 16;
    localparam int CNT_W        = 13;
    localparam int ACC_W        = 46;
    localparam int DIVC_W       = $clog2(ACC_W);
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STEP    = 2'd0,
        CFG_MAX_LAG       = 2'd1,
        CFG_LAG_STRIDE    = 2'd2,
        CFG_ORIGIN_STRIDE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } vec_t;

endpackage

// ===== hdl/vector_series_autocorrelation.sv =====
// ----------------------------------------------------------------------------
// vector_series_autocorrelation
// time autocorrelation of a series of 3-component Q1.15 vectors
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  sample    step_index vec_x vec_y vec_z end_of_series     start & !busy
//  result    lag_steps mean_correlation pair_count final_lag done, one cycle
//  config    cfg_index cfg_wdata                            cfg_we
//
// samples load one per cycle while busy is low; a sample with end_of_series
// starts a run; per lag each pair takes the one shared multiplier (three
// products per pair), then the sum takes the 46-step divider if there are
// pairs; after reset and after every run a clearing pass sweeps the store,
// one entry a cycle, with busy high; config writes are taken always
// results cannot be stalled: each is shown for one cycle with done
`include "vector_series_autocorrelation_defines.svh"

module vector_series_autocorrelation
    import vsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [STEP_W-1:0]        step_index,
    input  logic signed [COMP_W-1:0] vec_x,
    input  logic signed [COMP_W-1:0] vec_y,
    input  logic signed [COMP_W-1:0] vec_z,
    input  logic                     end_of_series,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [STEP_W-1:0]        cfg_wdata,
    output logic                     done,
    output logic [STEP_W-1:0]        lag_steps,
    output logic signed [31:0]       mean_correlation,
    output logic [CNT_W-1:0]         pair_count,
    output logic                     final_lag
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK, S_RD, S_M0, S_M1, S_M2, S_ACC, S_DIV, S_SAT, S_NEXT
    } state_t;

    state_t                    state_reg;
    logic [STEP_W-1:0]         start_step_reg, max_lag_reg, lag_stride_reg, origin_stride_reg;
    logic [STEP_W-1:0]         last_step_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;
    logic [STEP_W-1:0]         lag_reg;
    logic [LAGN_W-1:0]         n_reg;
    logic [CNT_W-1:0]          t0_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [31:0]        prod_reg;
    logic [ACC_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [CNT_W:0]            rem_reg;
    logic [DIVC_W-1:0]         divc_reg;
    logic                      done_reg, final_reg;
    logic [STEP_W-1:0]         lag_out_reg;
    logic signed [31:0]        mean_reg;
    logic [CNT_W-1:0]          cnt_out_reg;

    vec_t mem [SERIES_DEPTH];
    vec_t rd_a_reg, rd_b_reg;

    logic [STEP_W-1:0]         ls_eff, os_eff;
    logic [CNT_W:0]            tl_sum;
    logic [CNT_W-1:0]          next_lag;
    logic                      more_lags;
    logic signed [COMP_W-1:0]  mul_a, mul_b;
    logic signed [31:0]        mul_p;
    logic [CNT_W:0]            rem_shift;
    logic                      rem_ge;
    logic signed [ACC_W:0]     quo_s;
    logic signed [31:0]        sat_q;
    logic                      accept;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    vec_t                      mem_wdata;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign ls_eff    = (lag_stride_reg == '0) ? STEP_W'(1) : lag_stride_reg;
    assign os_eff    = (origin_stride_reg == '0) ? STEP_W'(1) : origin_stride_reg;
    assign tl_sum    = {1'b0, t0_reg} + {2'b0, lag_reg};
    assign next_lag  = {1'b0, lag_reg} + {1'b0, ls_eff};
    assign more_lags = (next_lag <= {1'b0, max_lag_reg})
                       && (n_reg + LAGN_W'(1) < LAGN_W'(MAX_LAGS));

    // shared multiplier, one component per cycle
    always_comb
    begin
        unique case (state_reg)
            S_M1:    begin mul_a = rd_a_reg.y; mul_b = rd_b_reg.y; end
            S_M2:    begin mul_a = rd_a_reg.z; mul_b = rd_b_reg.z; end
            default: begin mul_a = rd_a_reg.x; mul_b = rd_b_reg.x; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign rem_shift = {rem_reg[CNT_W-1:0], mag_reg[ACC_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count_reg});
    assign quo_s     = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    always_comb
    begin
        priority if (quo_s > $signed((ACC_W+1)'(32'sh7FFF_FFFF)))
            sat_q = 32'sh7FFF_FFFF;
        else if (quo_s < -$signed((ACC_W+1)'(33'sh0_8000_0000)))
            sat_q = 32'sh8000_0000;
        else
            sat_q = quo_s[31:0];
    end

    // store write port: samples while idle, zeros during the clearing pass
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = step_index[ADDR_W-1:0];
        mem_wdata = '{x: vec_x, y: vec_y, z: vec_z};
        if (accept)
            mem_we = 1'b1;
        else if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= mem[t0_reg[ADDR_W-1:0]];
        rd_b_reg <= mem[tl_sum[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_step_reg    <= '0;
            max_lag_reg       <= STEP_W'(63);
            lag_stride_reg    <= STEP_W'(1);
            origin_stride_reg <= STEP_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_STEP:    start_step_reg    <= cfg_wdata;
                CFG_MAX_LAG:       max_lag_reg       <= cfg_wdata;
                CFG_LAG_STRIDE:    lag_stride_reg    <= cfg_wdata;
                CFG_ORIGIN_STRIDE: origin_stride_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            last_step_reg <= '0;
            done_reg      <= 1'b0;
            lag_reg       <= '0;
            n_reg         <= '0;
            t0_reg        <= '0;
            count_reg     <= '0;
            divc_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(SERIES_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start && end_of_series)
                    begin
                        last_step_reg <= step_index;
                        lag_reg       <= '0;
                        n_reg         <= '0;
                        t0_reg        <= {1'b0, start_step_reg};
                        count_reg     <= '0;
                        acc_reg       <= '0;
                        state_reg     <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (tl_sum <= {2'b0, last_step_reg})
                        state_reg <= S_RD;
                    else if (count_reg == '0)
                    begin
                        mag_reg   <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= S_SAT;
                    end
                    else
                    begin
                        neg_reg   <= acc_reg[ACC_W-1];
                        mag_reg   <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                        rem_reg   <= '0;
                        divc_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_RD: state_reg <= S_M0;
                S_M0:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_M1;
                end
                S_M1, S_M2:
                begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= (state_reg == S_M1) ? S_M2 : S_ACC;
                end
                S_ACC:
                begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    count_reg <= count_reg + CNT_W'(1);
                    t0_reg    <= t0_reg + {1'b0, os_eff};
                    state_reg <= S_CHK;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_ge ? rem_shift - {1'b0, count_reg} : rem_shift;
                    mag_reg  <= {mag_reg[ACC_W-2:0], rem_ge};
                    divc_reg <= divc_reg + DIVC_W'(1);
                    if (divc_reg == DIVC_W'(ACC_W - 1))
                        state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    done_reg    <= 1'b1;
                    lag_out_reg <= lag_reg;
                    mean_reg    <= sat_q;
                    cnt_out_reg <= count_reg;
                    final_reg   <= !more_lags;
                    state_reg   <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (more_lags)
                    begin
                        lag_reg   <= next_lag[STEP_W-1:0];
                        n_reg     <= n_reg + LAGN_W'(1);
                        t0_reg    <= {1'b0, start_step_reg};
                        count_reg <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= S_CLEAR;
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    assign done             = done_reg;
    assign lag_steps        = lag_out_reg;
    assign mean_correlation = mean_reg;
    assign pair_count       = cnt_out_reg;
    assign final_lag        = final_reg;

    `VSA_ASSERT_NOW(a_done_busy, done, busy, "result outside a run")
    `VSA_ASSERT_NEXT(a_run_starts, start && !busy && end_of_series, busy, "run did not start")
    `VSA_ASSERT_NEXT(a_final_clears, done && final_lag, state_reg == S_CLEAR, "no clear after run")
    `VSA_ASSERT_NOW(a_count_range, done, pair_count <= CNT_W'(SERIES_DEPTH), "pair count too big")

endmodule

// ===== tb/tb_vector_series_autocorrelation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_series_autocorrelation
// checks the lag-by-lag mean dot products of short vector series against a
// local model of the store and the averaging, under random request gaps
// ----------------------------------------------------------------------------
module tb_vector_series_autocorrelation;
    import vsa_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int RANDOM_ITEMS = 410;

    typedef struct {
        logic [STEP_W-1:0] lag;
        logic signed [31:0] mean;
        logic [CNT_W-1:0] count;
        logic last;
    } lag_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [STEP_W-1:0] step_index = '0;
    logic signed [COMP_W-1:0] vec_x = '0;
    logic signed [COMP_W-1:0] vec_y = '0;
    logic signed [COMP_W-1:0] vec_z = '0;
    logic end_of_series = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0] cfg_wdata = '0;
    logic done;
    logic [STEP_W-1:0] lag_steps;
    logic signed [31:0] mean_correlation;
    logic [CNT_W-1:0] pair_count;
    logic final_lag;

    // model of the block
    vec_t series_mem [int];
    int last_step;
    logic [STEP_W-1:0] first_origin, top_lag, lag_step, origin_step;

    lag_result_t lag_results_q[$];
    int mismatches = 0;
    int requests_sent = 0;
    longint cycles = 0;

    vector_series_autocorrelation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .step_index(step_index), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .end_of_series(end_of_series), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .done(done), .lag_steps(lag_steps),
        .mean_correlation(mean_correlation), .pair_count(pair_count),
        .final_lag(final_lag)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vector_series_autocorrelation regression: fail");
            $finish;
        end
    end

    function automatic longint dot_of(int a, int b);
        vec_t va, vb;
        if (!series_mem.exists(a) || !series_mem.exists(b))
            return 0;
        va = series_mem[a];
        vb = series_mem[b];
        return longint'(va.x) * longint'(vb.x) + longint'(va.y) * longint'(vb.y)
             + longint'(va.z) * longint'(vb.z);
    endfunction

    // all lag results of one run, store cleared afterwards
    function automatic void predict_lags();
        int ls, os, n, lag, t0;
        longint sum, mean;
        int count;
        lag_result_t r;
        ls = (lag_step == 0) ? 1 : int'(lag_step);
        os = (origin_step == 0) ? 1 : int'(origin_step);
        n = 0;
        for (lag = 0; lag <= int'(top_lag) && n < MAX_LAGS; lag += ls)
        begin
            sum = 0;
            count = 0;
            for (t0 = int'(first_origin); t0 + lag <= last_step; t0 += os)
            begin
                sum += dot_of(t0, t0 + lag);
                count++;
            end
            mean = 0;
            if (count != 0)
            begin
                mean = sum / longint'(count);
                if (mean > 64'sd2147483647) mean = 64'sd2147483647;
                if (mean < -64'sd2147483648) mean = -64'sd2147483648;
            end
            r.lag = lag[STEP_W-1:0];
            r.mean = mean[31:0];
            r.count = count[CNT_W-1:0];
            r.last = 1'b0;
            lag_results_q.push_back(r);
            n++;
        end
        if (n > 0)
            lag_results_q[lag_results_q.size() - 1].last = 1'b1;
        series_mem.delete();
    endfunction

    function automatic void report(string what, longint exp_v, longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endfunction

    always @(posedge clk)
    begin : result_check
        lag_result_t e;
        if (rst_n && done)
        begin
            if (lag_results_q.size() == 0)
                report("unexpected result, lag", -1, lag_steps);
            else
            begin
                e = lag_results_q.pop_front();
                if (lag_steps !== e.lag) report("lag_steps", e.lag, lag_steps);
                if (mean_correlation !== e.mean)
                    report("mean_correlation", e.mean, mean_correlation);
                if (pair_count !== e.count) report("pair_count", e.count, pair_count);
                if (final_lag !== e.last) report("final_lag", e.last, final_lag);
            end
        end
    end

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (lag_results_q.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_config(logic [11:0] s, logic [11:0] m, logic [11:0] l,
                                logic [11:0] o);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_STEP;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_index <= CFG_MAX_LAG;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_index <= CFG_LAG_STRIDE;
        cfg_wdata <= l;
        @(posedge clk);
        cfg_index <= CFG_ORIGIN_STRIDE;
        cfg_wdata <= o;
        @(posedge clk);
        cfg_we <= 1'b0;
        first_origin = s;
        top_lag = m;
        lag_step = l;
        origin_step = o;
    endtask

    task automatic send_sample(int step, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic eos, int gap);
        vec_t v;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        step_index <= step[STEP_W-1:0];
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        end_of_series <= eos;
        do @(posedge clk); while (busy);
        v.x = x;
        v.y = y;
        v.z = z;
        series_mem[step] = v;
        requests_sent++;
        if (eos)
        begin
            last_step = step;
            predict_lags();
        end
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_defaults();
        send_sample(0, 16'h7fff, 16'h0000, 16'h8000, 1'b0, 0);
        send_sample(1, 16'h4000, 16'hc000, 16'h7fff, 1'b0, 2);
        send_sample(3, 16'hffff, 16'h0001, 16'h1234, 1'b1, 0);
    endtask

    task automatic test_saturation();
        write_config(12'd0, 12'd1, 12'd1, 12'd1);
        send_sample(0, 16'h8000, 16'h8000, 16'h8000, 1'b0, 0);
        send_sample(1, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 0);
        send_sample(2, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1);
    endtask

    // zero strides act as one, and too many lags are cut at the limit
    task automatic test_zero_stride_many_lags();
        write_config(12'd0, 12'd4095, 12'd0, 12'd0);
        send_sample(2, 16'h1111, 16'h2222, 16'h3333, 1'b0, 0);
        send_sample(0, 16'h8000, 16'h7fff, 16'h0000, 1'b0, 0);
        send_sample(4, 16'hc000, 16'h4000, 16'h8001, 1'b1, 0);
    endtask

    task automatic test_start_after_last();
        write_config(12'd4095, 12'd2, 12'd1, 12'd1);
        send_sample(5, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 3);
        send_sample(10, 16'h0100, 16'h0200, 16'h0300, 1'b1, 0);
    endtask

    // top of the store, widest pair count
    task automatic test_full_depth();
        write_config(12'd0, 12'd0, 12'd4095, 12'd1);
        send_sample(4095, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, 0);
        send_sample(2048, 16'h8000, 16'h8000, 16'h8000, 1'b0, 0);
        send_sample(4095, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 0);
        write_config(12'd4000, 12'd95, 12'd4095, 12'd4095);
        send_sample(4000, 16'h5555, 16'haaaa, 16'h0f0f, 1'b0, 0);
        send_sample(4095, 16'haaaa, 16'h5555, 16'hf0f0, 1'b1, 0);
    endtask

    task automatic test_random_series();
        int last, st, n, step;
        bit deep, no_gaps;
        logic [11:0] ml, ls, os;
        while (requests_sent < RANDOM_ITEMS)
        begin
            deep = ($urandom_range(0, 7) == 0);
            last = deep ? $urandom_range(3968, 4095) : $urandom_range(0, 48);
            if (deep)
                st = last - $urandom_range(0, 40);
            else if ($urandom_range(0, 5) == 0)
                st = $urandom_range(0, 4095);
            else
                st = $urandom_range(0, 6);
            case ($urandom_range(0, 3))
                0: ml = 12'd0;
                1: ml = 12'd4095;
                default: ml = 12'($urandom_range(0, 80));
            endcase
            case ($urandom_range(0, 4))
                0: ls = 12'd0;
                1: ls = 12'd4095;
                default: ls = 12'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 4))
                0: os = 12'd0;
                1: os = 12'd4095;
                default: os = 12'($urandom_range(1, 4));
            endcase
            write_config(st[11:0], ml, ls, os);
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 20);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    step = $urandom_range(0, 4095);
                else
                    step = deep ? $urandom_range(st, last) : $urandom_range(0, last);
                send_sample(step, pick_comp(), pick_comp(), pick_comp(), 1'b0,
                            no_gaps ? 0 : $urandom_range(0, 5));
            end
            send_sample(last, pick_comp(), pick_comp(), pick_comp(), 1'b1,
                        no_gaps ? 0 : $urandom_range(0, 5));
        end
    endtask

    initial
    begin
        last_step = 0;
        first_origin = 12'd0;
        top_lag = 12'd63;
        lag_step = 12'd1;
        origin_step = 12'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_saturation();
        test_zero_stride_many_lags();
        test_start_after_last();
        test_full_depth();
        test_random_series();
        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && lag_results_q.size() == 0)
            $display("vector_series_autocorrelation regression: pass");
        else
            $display("vector_series_autocorrelation regression: fail");
        $finish;
    end

endmodule
